/* design/point_transform_zbuffer_plotter_macros.svh */
// Assertion helpers for the point plotter.
`ifndef POINT_TRANSFORM_ZBUFFER_PLOTTER_MACROS_SVH
`define POINT_TRANSFORM_ZBUFFER_PLOTTER_MACROS_SVH

// Same-cycle property, clocked on i_clk, off during reset.
`define PTZB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define PTZB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/ptzb_pkg.sv */
package ptzb_pkg;

    localparam int DEF_GRID_ROWS = 42;
    localparam int DEF_GRID_COLS = 165;

    localparam int REQ_W    = 2;
    localparam int COORD_W  = 16;
    localparam int ROW_W    = 6;
    localparam int COL_W    = 8;
    localparam int GLYPH_W  = 8;
    localparam int SHADE_W  = 4;
    localparam int CFG_IDX_W = 1;
    localparam int IN_W     = 112;   // 110 field bits, padded to bytes
    localparam int OUT_W    = 40;

    // internal datapath widths
    localparam int VEC_W    = 24;    // rotated coordinates, growth without saturation
    localparam int DIF_W    = 25;    // z - 1.5
    localparam int SUM_W    = 26;    // x + d, y + d
    localparam int NUM_W    = 38;    // projection numerators, grid up to 256
    localparam int DEN_W    = 30;    // projection denominators
    localparam int CNT_W    = 6;     // divider step count
    localparam int IDX_W    = 8;     // grid index, grid up to 256
    localparam int EPOCH_W  = 8;

    localparam int FRAC_BITS    = 14;
    localparam int EYE_OFFSET   = 24576;
    localparam int SHADE_LEVELS = 12;
    localparam int SHADE_MUL    = 12;
    localparam int COS_RESET    = 16384;
    localparam logic [GLYPH_W-1:0] GLYPH_SPACE = 8'd32;

    localparam logic [CFG_IDX_W-1:0] CFG_SIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COS = 1'b1;

    typedef enum logic [REQ_W-1:0] {
        REQ_PLOT  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_FRAME = 2'd2
    } t_req;

    // result item, written in the lowest bit
    typedef struct packed {
        logic signed [COORD_W-1:0] depth;
        logic [GLYPH_W-1:0]        glyph;
        logic [COL_W-1:0]          col;
        logic [ROW_W-1:0]          row;
        logic                      off_grid;
        logic                      written;
    } t_result;

    typedef struct packed {
        logic [EPOCH_W-1:0]        epoch;
        logic [SHADE_W-1:0]        shade;
        logic signed [COORD_W-1:0] depth;
    } t_cell;

    function automatic logic [GLYPH_W-1:0] glyph_of(input logic [SHADE_W-1:0] idx);
        logic [GLYPH_W-1:0] g;
        case (idx)
            4'd0, 4'd12: g = 8'h2E;   // .
            4'd1, 4'd13: g = 8'h2C;   // ,
            4'd2, 4'd14: g = 8'h2D;   // -
            4'd3, 4'd15: g = 8'h7E;   // ~
            4'd4:        g = 8'h3A;   // :
            4'd5:        g = 8'h3B;   // ;
            4'd6:        g = 8'h3D;   // =
            4'd7:        g = 8'h21;   // !
            4'd8:        g = 8'h2A;   // *
            4'd9:        g = 8'h23;   // #
            4'd10:       g = 8'h24;   // $
            4'd11:       g = 8'h40;   // @
            default:     g = GLYPH_SPACE;
        endcase
        return g;
    endfunction

endpackage

/* design/point_transform_zbuffer_plotter.sv */
// Channel      Direction  Ports                        Contents
// ----------   ---------  ---------------------------  ---------------------------------
// cfg write    in         i_cfg_valid / o_cfg_ready    index 0 sin, 1 cos (Q1.14)
// item in      in         i_s_axis_*                   tuser: req_type; tdata: point
// result out   out        o_m_axis_*                   tdata: one result per item
//
// Plot: 12 rotation steps on one shared multiplier pair, two 38-step restoring divisions,
//   a cell read-modify-write; a point dropped at the eye plane skips the divisions and the cell.
// Read: range check, cell read, result. New frame: epoch advance, or a clearing sweep when the frame epoch wraps.
// After reset a clearing pass writes every cell, with o_s_axis_tready low; config writes
//   are taken throughout.
// A finished result waits in the output register; the next item is taken meanwhile.
module point_transform_zbuffer_plotter #(
    parameter int GRID_ROWS = ptzb_pkg::DEF_GRID_ROWS,
    parameter int GRID_COLS = ptzb_pkg::DEF_GRID_COLS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ptzb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ptzb_pkg::COORD_W-1:0]    i_cfg_data,
    // item input
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // vertex_x, vertex_y, vertex_z, normal_x, normal_y, normal_z, read_row, read_col, pad
    input  logic [ptzb_pkg::IN_W-1:0]       i_s_axis_tdata,
    // req_type
    input  logic [ptzb_pkg::REQ_W-1:0]      i_s_axis_tuser,
    // result output
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // written, off_grid, cell_row, cell_col, glyph, depth
    output logic [ptzb_pkg::OUT_W-1:0]      o_m_axis_tdata
);

    localparam int CELLS  = GRID_ROWS * GRID_COLS;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int COL_K  = 3 * GRID_COLS;

    localparam int VW = ptzb_pkg::VEC_W;
    localparam int NW = ptzb_pkg::NUM_W;
    localparam int DW = ptzb_pkg::DEN_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ROT, S_PREP, S_NUM, S_DIV, S_CHK, S_RD, S_UPD, S_OUT
    } t_state;

    t_state r_state;

    logic signed [ptzb_pkg::COORD_W-1:0] r_sin, r_cos;
    logic [ptzb_pkg::EPOCH_W-1:0]        r_epoch;
    logic [ADDR_W-1:0]                   r_clr_addr;
    logic                                r_clr_res;

    // rotation registers: point, normal, temp
    logic signed [VW-1:0] r_vx, r_vy, r_vz, r_nx, r_ny, r_nz, r_t;
    logic [2:0]           r_phase;
    logic                 r_vsel;

    // projection
    logic signed [ptzb_pkg::DIF_W-1:0]   r_d;
    logic signed [ptzb_pkg::SUM_W-1:0]   r_sum_x, r_sum_y;
    logic signed [ptzb_pkg::COORD_W-1:0] r_depth;
    logic [ptzb_pkg::SHADE_W-1:0]        r_shade;

    // divider
    logic [DW-1:0]                 r_dv_rem, r_dv_den, r_col_den;
    logic [NW-1:0]                 r_dv_quo, r_col_mag;
    logic [ptzb_pkg::CNT_W-1:0]    r_dv_cnt;
    logic                          r_dv_neg, r_col_neg, r_pass, r_row_ok;

    logic [ptzb_pkg::IDX_W-1:0]    r_cell_row, r_cell_col;
    logic                          r_in_range, r_is_read;
    logic [ADDR_W-1:0]             r_addr;

    ptzb_pkg::t_result r_res, r_m_data;
    logic              r_m_valid;

    ptzb_pkg::t_cell   r_mem [CELLS];
    ptzb_pkg::t_cell   r_rd_word;

    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    ptzb_pkg::t_cell   w_wdata;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    // input fields
    logic signed [ptzb_pkg::COORD_W-1:0] w_ivx, w_ivy, w_ivz, w_inx, w_iny, w_inz;
    logic [ptzb_pkg::ROW_W-1:0]          w_irow;
    logic [ptzb_pkg::COL_W-1:0]          w_icol;
    assign w_ivx  = i_s_axis_tdata[15:0];
    assign w_ivy  = i_s_axis_tdata[31:16];
    assign w_ivz  = i_s_axis_tdata[47:32];
    assign w_inx  = i_s_axis_tdata[63:48];
    assign w_iny  = i_s_axis_tdata[79:64];
    assign w_inz  = i_s_axis_tdata[95:80];
    assign w_irow = i_s_axis_tdata[101:96];
    assign w_icol = i_s_axis_tdata[109:102];

    // ---- rotation step: fx(a*cos + b*(+/-sin)) ----
    logic signed [VW-1:0] w_ax, w_ay, w_az, w_opa, w_opb, w_rot;
    logic signed [16:0]   w_seff;
    logic                 w_sneg;
    logic signed [VW+16:0] w_pa, w_pb;
    logic signed [VW+17:0] w_sum;

    always_comb begin
        w_ax = r_vsel ? r_nx : r_vx;
        w_ay = r_vsel ? r_ny : r_vy;
        w_az = r_vsel ? r_nz : r_vz;
        w_opa = w_ax;
        w_opb = w_az;
        w_sneg = 1'b0;
        case (r_phase)
            3'd0: begin w_opa = w_ax; w_opb = w_az; w_sneg = 1'b0; end  // x1 about Y
            3'd1: begin w_opa = w_az; w_opb = w_ax; w_sneg = 1'b1; end  // z1
            3'd2: begin w_opa = w_ax; w_opb = w_ay; w_sneg = 1'b1; end  // x2 about Z
            3'd3: begin w_opa = w_ay; w_opb = w_ax; w_sneg = 1'b0; end  // y2
            3'd4: begin w_opa = w_ay; w_opb = w_az; w_sneg = 1'b1; end  // y3 about X
            3'd5: begin w_opa = w_az; w_opb = w_ay; w_sneg = 1'b0; end  // z3
            default: begin w_opa = w_ax; w_opb = w_az; w_sneg = 1'b0; end
        endcase
        w_seff = w_sneg ? -17'(r_sin) : 17'(r_sin);
        w_pa   = w_opa * r_cos;
        w_pb   = w_opb * w_seff;
        w_sum  = (VW+18)'(w_pa) + (VW+18)'(w_pb);
        w_rot  = VW'(w_sum >>> ptzb_pkg::FRAC_BITS);
    end

    // ---- depth, shade, eye offset ----
    logic                                w_zsat;
    logic signed [ptzb_pkg::COORD_W-1:0] w_depth;
    logic [VW+3:0]                       w_nz12;
    logic [VW+3:0]                       w_shq;
    logic [ptzb_pkg::SHADE_W-1:0]        w_shade;
    logic signed [ptzb_pkg::DIF_W-1:0]   w_d;

    always_comb begin
        w_zsat  = (r_vz[VW-1:15] != {(VW-15){r_vz[VW-1]}});
        w_depth = w_zsat ? (r_vz[VW-1] ? 16'sh8000 : 16'sh7FFF) : r_vz[15:0];
        w_nz12  = (VW+4)'(r_nz[VW-2:0]) * (VW+4)'(ptzb_pkg::SHADE_MUL);
        w_shq   = w_nz12 >> ptzb_pkg::FRAC_BITS;
        if (r_nz[VW-1] || r_nz == '0) begin
            w_shade = '0;
        end else if (w_shq > (VW+4)'(ptzb_pkg::SHADE_LEVELS - 1)) begin
            w_shade = ptzb_pkg::SHADE_W'(ptzb_pkg::SHADE_LEVELS - 1);
        end else begin
            w_shade = w_shq[ptzb_pkg::SHADE_W-1:0];
        end
        w_d = ptzb_pkg::DIF_W'(r_vz) - ptzb_pkg::DIF_W'(ptzb_pkg::EYE_OFFSET);
    end

    // ---- numerators and denominators, sign folded into numerator ----
    logic signed [NW-1:0]           w_nrow, w_ncol;
    logic [NW-1:0]                  w_row_mag, w_col_mag;
    logic [ptzb_pkg::DIF_W-1:0]     w_dabs;
    logic [DW-1:0]                  w_den_row, w_den_col;

    always_comb begin
        w_nrow    = NW'(r_sum_y) * NW'(GRID_ROWS);
        w_ncol    = NW'(r_sum_x) * NW'(COL_K);
        w_row_mag = w_nrow[NW-1] ? NW'(-w_nrow) : NW'(w_nrow);
        w_col_mag = w_ncol[NW-1] ? NW'(-w_ncol) : NW'(w_ncol);
        w_dabs    = r_d[ptzb_pkg::DIF_W-1] ? ptzb_pkg::DIF_W'(-r_d) : ptzb_pkg::DIF_W'(r_d);
        w_den_row = DW'(w_dabs) << 1;
        w_den_col = DW'(w_dabs) * DW'(10);
    end

    // ---- restoring divider step, floor on sign ----
    logic [DW:0]    w_rem_sh;
    logic [DW+1:0]  w_diff;
    logic           w_ge, w_dv_last, w_dv_ok;
    logic [DW-1:0]  w_rem_n;
    logic [NW-1:0]  w_quo_n, w_fq, w_lim;

    always_comb begin
        w_rem_sh  = {r_dv_rem, r_dv_quo[NW-1]};
        w_diff    = {1'b0, w_rem_sh} - {2'b00, r_dv_den};
        w_ge      = !w_diff[DW+1];
        w_rem_n   = w_ge ? w_diff[DW-1:0] : w_rem_sh[DW-1:0];
        w_quo_n   = {r_dv_quo[NW-2:0], w_ge};
        w_dv_last = (r_dv_cnt == ptzb_pkg::CNT_W'(NW - 1));
        w_fq      = r_dv_neg ? (-(w_quo_n + NW'(w_rem_n != '0))) : w_quo_n;
        w_lim     = r_pass ? NW'(GRID_COLS) : NW'(GRID_ROWS);
        w_dv_ok   = !w_fq[NW-1] && (w_fq < w_lim);
    end

    // ---- cell update ----
    logic w_full, w_upd_wr;
    assign w_full   = (r_rd_word.epoch == r_epoch);
    assign w_upd_wr = !w_full || (r_depth > r_rd_word.depth);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_addr;
        w_wdata = '{epoch: r_epoch, shade: r_shade, depth: r_depth};
        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
                w_wdata = '0;
            end
            S_UPD: begin
                w_we = !r_is_read && w_upd_wr;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RD) begin
            r_rd_word <= r_mem[r_addr];
        end
    end

    // ---- control ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_epoch    <= '0;
            r_clr_addr <= '0;
            r_clr_res  <= 1'b0;
            r_m_valid  <= 1'b0;
            r_sin      <= '0;
            r_cos      <= ptzb_pkg::COORD_W'(ptzb_pkg::COS_RESET);
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    ptzb_pkg::CFG_SIN: r_sin <= i_cfg_data;
                    ptzb_pkg::CFG_COS: r_cos <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_m_valid && i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == ADDR_W'(CELLS - 1)) begin
                        r_clr_addr <= '0;
                        r_epoch    <= ptzb_pkg::EPOCH_W'(1);
                        r_state    <= r_clr_res ? S_OUT : S_IDLE;
                    end
                end

                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_res <= '0;
                        case (ptzb_pkg::t_req'(i_s_axis_tuser))
                            ptzb_pkg::REQ_PLOT: begin
                                r_vx      <= VW'(w_ivx);
                                r_vy      <= VW'(w_ivy);
                                r_vz      <= VW'(w_ivz);
                                r_nx      <= VW'(w_inx);
                                r_ny      <= VW'(w_iny);
                                r_nz      <= VW'(w_inz);
                                r_phase   <= '0;
                                r_vsel    <= 1'b0;
                                r_is_read <= 1'b0;
                                r_state   <= S_ROT;
                            end
                            ptzb_pkg::REQ_READ: begin
                                r_is_read  <= 1'b1;
                                r_cell_row <= ptzb_pkg::IDX_W'(w_irow);
                                r_cell_col <= w_icol;
                                r_in_range <= (32'(w_irow) < 32'(GRID_ROWS))
                                           && (32'(w_icol) < 32'(GRID_COLS));
                                r_state    <= S_CHK;
                            end
                            ptzb_pkg::REQ_FRAME: begin
                                // epoch advance empties all cells; wrap needs a sweep
                                if (&r_epoch) begin
                                    r_clr_res  <= 1'b1;
                                    r_clr_addr <= '0;
                                    r_state    <= S_CLEAR;
                                end else begin
                                    r_epoch <= r_epoch + 1'b1;
                                    r_state <= S_OUT;
                                end
                            end
                            default: begin
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end

                S_ROT: begin
                    case (r_phase)
                        3'd0, 3'd2, 3'd4: r_t <= w_rot;
                        3'd1: begin
                            if (r_vsel) begin r_nz <= w_rot; r_nx <= r_t; end
                            else begin r_vz <= w_rot; r_vx <= r_t; end
                        end
                        3'd3: begin
                            if (r_vsel) begin r_ny <= w_rot; r_nx <= r_t; end
                            else begin r_vy <= w_rot; r_vx <= r_t; end
                        end
                        3'd5: begin
                            if (r_vsel) begin r_nz <= w_rot; r_ny <= r_t; end
                            else begin r_vz <= w_rot; r_vy <= r_t; end
                        end
                        default: ;
                    endcase
                    if (r_phase == 3'd5) begin
                        r_phase <= '0;
                        r_vsel  <= 1'b1;
                        if (r_vsel) begin
                            r_state <= S_PREP;
                        end
                    end else begin
                        r_phase <= r_phase + 1'b1;
                    end
                end

                S_PREP: begin
                    r_depth <= w_depth;
                    r_shade <= w_shade;
                    r_d     <= w_d;
                    r_sum_x <= ptzb_pkg::SUM_W'(r_vx) + ptzb_pkg::SUM_W'(w_d);
                    r_sum_y <= ptzb_pkg::SUM_W'(r_vy) + ptzb_pkg::SUM_W'(w_d);
                    if (w_d == '0) begin
                        // projection at the eye plane: dropped
                        r_res.off_grid <= 1'b1;
                        r_res.depth    <= w_depth;
                        r_state        <= S_OUT;
                    end else begin
                        r_state <= S_NUM;
                    end
                end

                S_NUM: begin
                    r_dv_quo  <= w_row_mag;
                    r_dv_den  <= w_den_row;
                    r_dv_neg  <= w_nrow[NW-1] ^ r_d[ptzb_pkg::DIF_W-1];
                    r_dv_rem  <= '0;
                    r_dv_cnt  <= '0;
                    r_pass    <= 1'b0;
                    r_col_mag <= w_col_mag;
                    r_col_den <= w_den_col;
                    r_col_neg <= w_ncol[NW-1] ^ r_d[ptzb_pkg::DIF_W-1];
                    r_state   <= S_DIV;
                end

                S_DIV: begin
                    r_dv_rem <= w_rem_n;
                    r_dv_quo <= w_quo_n;
                    r_dv_cnt <= r_dv_cnt + 1'b1;
                    if (w_dv_last) begin
                        r_dv_cnt <= '0;
                        if (!r_pass) begin
                            r_cell_row <= w_fq[ptzb_pkg::IDX_W-1:0];
                            r_row_ok   <= w_dv_ok;
                            r_dv_quo   <= r_col_mag;
                            r_dv_den   <= r_col_den;
                            r_dv_neg   <= r_col_neg;
                            r_dv_rem   <= '0;
                            r_pass     <= 1'b1;
                        end else begin
                            r_cell_col <= w_fq[ptzb_pkg::IDX_W-1:0];
                            r_in_range <= r_row_ok && w_dv_ok;
                            r_state    <= S_CHK;
                        end
                    end
                end

                S_CHK: begin
                    if (!r_in_range) begin
                        r_res.off_grid <= 1'b1;
                        if (r_is_read) begin
                            r_res.row   <= r_cell_row[ptzb_pkg::ROW_W-1:0];
                            r_res.col   <= r_cell_col;
                            r_res.glyph <= ptzb_pkg::GLYPH_SPACE;
                        end else begin
                            r_res.depth <= r_depth;
                        end
                        r_state <= S_OUT;
                    end else begin
                        r_addr  <= ADDR_W'(32'(r_cell_row) * 32'(GRID_COLS) + 32'(r_cell_col));
                        r_state <= S_RD;
                    end
                end

                S_RD: begin
                    r_state <= S_UPD;
                end

                S_UPD: begin
                    r_res.row <= r_cell_row[ptzb_pkg::ROW_W-1:0];
                    r_res.col <= r_cell_col;
                    if (r_is_read) begin
                        r_res.glyph <= w_full ? ptzb_pkg::glyph_of(r_rd_word.shade)
                                              : ptzb_pkg::GLYPH_SPACE;
                        r_res.depth <= w_full ? r_rd_word.depth : '0;
                    end else begin
                        r_res.written <= w_upd_wr;
                        r_res.glyph   <= ptzb_pkg::glyph_of(r_shade);
                        r_res.depth   <= r_depth;
                    end
                    r_state <= S_OUT;
                end

                S_OUT: begin
                    if (!r_m_valid || i_m_axis_tready) begin
                        r_m_data  <= r_res;
                        r_m_valid <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`include "point_transform_zbuffer_plotter_macros.svh"

    `PTZB_ASSERT(a_no_write_idle, w_we |-> (r_state != S_IDLE && r_state != S_OUT), "stray write")
    `PTZB_ASSERT(a_epoch_live, o_s_axis_tready |-> (r_epoch != '0), "epoch zero while idle")
    `PTZB_ASSERT(a_addr_range, (r_state == S_RD) |-> (32'(r_addr) < CELLS), "bad address")
    `PTZB_ASSERT_NEXT(a_upd_then_out, r_state == S_UPD, r_state == S_OUT, "update stalled")

endmodule
